// ===== rtl/did_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the digital input debouncer.
// No dependencies; every other source file uses this package.
package did_pkg;

  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = TICKS_W;

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW     = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2
  } edge_t;

  typedef struct packed {
    logic [TICKS_W-1:0] debounce_ticks;
    logic               active_low;
  } cfg_t;

  typedef struct packed {
    logic               active;
    edge_t              edge_event;
    logic [TICKS_W-1:0] ticks_left;
  } res_t;

endpackage

// ===== rtl/did_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample and result streams.
// Depends on did_pkg for field widths.
interface did_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

interface did_out_if;
  logic                       valid;
  logic                       ready;
  logic                       active;
  logic [1:0]                 edge_event;
  logic [did_pkg::TICKS_W-1:0] ticks_left;

  modport source (output valid, output active, output edge_event, output ticks_left,
                  input ready);
  modport sink   (input valid, input active, input edge_event, input ticks_left,
                  output ready);
endinterface

// ===== rtl/did_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: debounce time and polarity.
// Depends on did_pkg.
module did_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [did_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [did_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output did_pkg::cfg_t                  cfg
);
  import did_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata[TICKS_W-1:0];
        CFG_ACTIVE_LOW:     cfg_r.active_low     <= cfg_wdata[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/did_core.sv =====
`timescale 1ns / 1ps
// Debounce state (level, countdown) and per-sample result logic.
// Depends on did_pkg.
module did_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          raw_level,
  input  did_pkg::cfg_t cfg,
  output did_pkg::res_t res
);
  import did_pkg::*;

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic                   level_r, level_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] load_val;
  logic [31:0]            ticks_ext;
  logic [31:0]            count_ext;
  logic                   flip;

  // Saturate the load when the counter is narrower than the register
  always_comb begin
    ticks_ext = 32'(cfg.debounce_ticks);
    load_val  = (ticks_ext > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                       : ticks_ext[COUNT_WIDTH-1:0];
  end

  always_comb begin
    count_nxt = count_r;
    flip      = 1'b0;
    if (cfg.debounce_ticks == '0) begin
      count_nxt = '0;
      flip      = (raw_level != level_r);
    end else if (count_r == '0) begin
      if (raw_level != level_r) count_nxt = load_val;
    end else begin
      count_nxt = count_r - COUNT_WIDTH'(1);
      if (count_nxt == '0) flip = (raw_level != level_r);
    end
    level_nxt = flip ? raw_level : level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      count_r <= '0;
    end else if (take) begin
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    count_ext      = 32'(count_nxt);
    res.active     = level_nxt ^ cfg.active_low;
    res.ticks_left = count_ext[TICKS_W-1:0];
    if (!flip)
      res.edge_event = EDGE_NONE;
    else if (level_nxt ^ cfg.active_low)
      res.edge_event = EDGE_RISE;
    else
      res.edge_event = EDGE_FALL;
  end

endmodule

// ===== rtl/did_outreg.sv =====
`timescale 1ns / 1ps
// Result register between the core and the output channel.
// Depends on did_pkg.
module did_outreg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  did_pkg::res_t res,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          can_load,
  output did_pkg::res_t out_res
);
  import did_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/digital_input_debouncer.sv =====
`timescale 1ns / 1ps
// Digital input debouncer. One raw pin sample is taken per input transfer and
// one result (logical level, edge event, countdown) is produced per sample, in
// the cycle after, from the result register. Throughput is one sample per
// cycle; in_ready drops only while a result sits in the output register and
// out_ready is low. A mismatch against the debounced level loads the
// countdown with debounce_ticks (saturated at COUNT_WIDTH bits); when the
// countdown hits zero the raw level is checked again and the level flips
// only if the mismatch is still there. debounce_ticks of zero bypasses the
// filter: the level follows the sample and the countdown is held at zero.
// active_low inverts the reported level and swaps rising/falling. Write the
// configuration only while no results are outstanding; unknown indexes are
// ignored. Depends on did_pkg, did_if, did_cfg, did_core and did_outreg.
module digital_input_debouncer #(
  parameter int unsigned COUNT_WIDTH = 16  // countdown width, 1..32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  did_in_if.sink                         in_ch,
  did_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [did_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [did_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import did_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic can_load;
  logic in_xfer;

  // A sample transfer updates state and loads the result register together
  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && can_load;

  did_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  did_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_xfer),
    .raw_level (in_ch.raw_level),
    .cfg       (cfg),
    .res       (core_res)
  );

  did_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .res       (core_res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign out_ch.active     = out_res.active;
  assign out_ch.edge_event = out_res.edge_event;
  assign out_ch.ticks_left = out_res.ticks_left;

endmodule

// ===== rtl/did_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the debouncer, bound to the top level.
// Depends on did_pkg and digital_input_debouncer.
module did_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_edge,
  input logic [did_pkg::TICKS_W-1:0] out_ticks
);
  import did_pkg::*;

  // edge code 3 never leaves the block
  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_edge == EDGE_NONE || out_edge == EDGE_RISE ||
                   out_edge == EDGE_FALL))
    else $error("illegal edge code");

  // a level change only happens with the countdown idle
  a_edge_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_edge != EDGE_NONE) |-> (out_ticks == '0))
    else $error("edge reported with countdown running");

  // an empty result register never blocks samples
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_edge) && $stable(out_ticks)))
    else $error("stalled result changed");

endmodule

bind digital_input_debouncer did_checker u_did_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_edge  (out_ch.edge_event),
  .out_ticks (out_ch.ticks_left)
);

// ===== tb/sv/digital_input_debouncer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for digital_input_debouncer: streams pin samples,
// predicts every result and checks level, edge and countdown field by field.
// Depends on did_pkg, did_if and the RTL top level.
module digital_input_debouncer_tb;
  import did_pkg::*;

  // Writes to these indexes must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 130;
  localparam int STALL_LEN  = 80;
  localparam int SHOW_MAX   = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  did_in_if  in_ch ();
  did_out_if out_ch ();

  digital_input_debouncer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the configuration registers, updated after each write lands
  logic [TICKS_W-1:0] cfg_ticks;
  logic               cfg_low;

  // Predicted debouncer state
  logic               deb_level;
  logic [TICKS_W-1:0] deb_cnt;

  logic pin_samples[$];        // samples waiting to be offered
  res_t predicted_results[$];  // one per accepted sample, oldest first

  int unsigned pushed_cnt, taken_cnt, result_cnt, err_cnt;
  int unsigned rise_cnt, fall_cnt, cfg_writes;
  int          in_gap, out_gap;
  logic        in_idle, out_idle, hold_off;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One sample tick of the debouncer. Countdown is 16 bits here, so a load
  // never needs to saturate.
  function automatic res_t debounce_tick(input logic raw);
    edge_t mark;
    res_t  r;
    mark = EDGE_NONE;
    if (cfg_ticks == '0) begin
      // bypass: follow the pin, and kill any countdown still running
      deb_cnt = '0;
      if (raw != deb_level) begin
        deb_level = raw;
        mark = raw ? EDGE_RISE : EDGE_FALL;
      end
    end else if (deb_cnt == '0) begin
      if (raw != deb_level) deb_cnt = cfg_ticks;
    end else begin
      deb_cnt = deb_cnt - TICKS_W'(1);
      // re-check only on the tick the countdown expires
      if (deb_cnt == '0 && raw != deb_level) begin
        deb_level = raw;
        mark = raw ? EDGE_RISE : EDGE_FALL;
      end
    end
    if (cfg_low && mark != EDGE_NONE) mark = (mark == EDGE_RISE) ? EDGE_FALL : EDGE_RISE;
    r.active     = deb_level ^ cfg_low;
    r.edge_event = mark;
    r.ticks_left = deb_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < SHOW_MAX)
      $display("MISMATCH at result %0d: %s got %0d expected %0d", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // Sample driver. A new wait is drawn after every transfer; valid holds
  // steady while the block stalls.
  always @(posedge clk) begin : sample_driver
    logic took;
    took = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(debounce_tick(in_ch.raw_level));
        taken_cnt++;
        took = 1'b1;
        in_gap = in_idle ? $urandom_range(0, 6) : 0;
      end
      if (!in_ch.valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pin_samples.size() != 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.raw_level <= pin_samples.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing pending:", 1, 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.active !== want.active)
            report_mismatch("active", out_ch.active, want.active);
          if (out_ch.edge_event !== want.edge_event)
            report_mismatch("edge_event", out_ch.edge_event, want.edge_event);
          if (out_ch.ticks_left !== want.ticks_left)
            report_mismatch("ticks_left", out_ch.ticks_left, want.ticks_left);
          if (want.edge_event == EDGE_RISE) rise_cnt++;
          if (want.edge_event == EDGE_FALL) fall_cnt++;
        end
        out_gap = out_idle ? $urandom_range(0, 6) : 0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !hold_off;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_DEBOUNCE_TICKS: cfg_ticks = val;
      CFG_ACTIVE_LOW:     cfg_low   = val[0];
      default: ;
    endcase
  endtask

  // Polarity write with junk in the unused upper bits
  task automatic write_polarity(input logic low);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom);
    val[0] = low;
    write_reg(CFG_ACTIVE_LOW, val);
  endtask

  task automatic push_run(input logic level, input int n);
    repeat (n) pin_samples.push_back(level);
    pushed_cnt += n;
  endtask

  // Done when every offered sample got in and every result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (taken_cnt != pushed_cnt || predicted_results.size() != 0);
  endtask

  // Main sequence: reset, directed cases, then random phases
  initial begin : stimulus
    int   t, n, len, pick;
    logic cur;
    in_ch.valid     = 1'b0;
    in_ch.raw_level = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    cfg_ticks       = '0;
    cfg_low         = 1'b0;
    deb_level       = 1'b0;
    deb_cnt         = '0;
    in_idle         = 1'b0;
    out_idle        = 1'b0;
    hold_off        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Bypass out of reset: level tracks the pin, edges against last sample
    push_run(1'b1, 2);
    push_run(1'b0, 2);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    wait_drained();

    // Inverted polarity, still bypassed
    write_polarity(1'b1);
    push_run(1'b1, 1);
    push_run(1'b0, 2);
    wait_drained();

    // Short debounce: a change that holds, then a glitch that does not
    write_reg(CFG_DEBOUNCE_TICKS, 16'd2);
    write_polarity(1'b0);
    push_run(1'b1, 3);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    wait_drained();

    // Unknown indexes must leave both registers alone
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '0);
    push_run(1'b0, 3);
    wait_drained();

    // Longest debounce time, then bypass while that countdown is running
    write_reg(CFG_DEBOUNCE_TICKS, '1);
    write_polarity(1'b1);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    wait_drained();
    write_reg(CFG_DEBOUNCE_TICKS, '0);
    push_run(1'b1, 1);
    wait_drained();

    // Random phases. Phase boundaries fall mid-countdown at random, so new
    // debounce times also get written while a count is in progress.
    cur = deb_level;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       t = 1;
        1:       t = 65535;
        2:       t = 0;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0)      t = 0;
          else if (pick <= 7) t = $urandom_range(1, 8);
          else if (pick == 8) t = $urandom_range(9, 40);
          else                t = 65535;
        end
      endcase
      write_reg(CFG_DEBOUNCE_TICKS, TICKS_W'(t));
      write_polarity(1'($urandom_range(0, 1)));
      // a few phases run flat out on both sides
      in_idle  <= ($urandom_range(0, 3) != 0);
      out_idle <= ($urandom_range(0, 3) != 0);
      n = 0;
      while (n < PHASE_LEN) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          // change that holds long enough to get through the filter, unless the debounce time is above 40
          cur = !cur;
          len = (t > 40) ? $urandom_range(1, 20) : $urandom_range(t + 1, 2 * t + 4);
          push_run(cur, len);
        end else if (pick <= 8) begin
          // bounce no longer than the debounce time (one sample when bypassed)
          len = (t > 40) ? $urandom_range(1, 3) : $urandom_range(1, (t > 0) ? t : 1);
          push_run(!cur, len);
        end else begin
          len = 1;
          push_run(1'($urandom_range(0, 1)), 1);
        end
        n += len;
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Ran %0d samples through %0d register writes; %0d results checked.",
             taken_cnt, cfg_writes, result_cnt);
    $display("Saw %0d rising and %0d falling edges, bypass, inversion and a long stall.",
             rise_cnt, fall_cnt);
    if (err_cnt == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, predicted_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Long receiver stall while samples are still queued, so the output
  // register fills and in_ready has to drop.
  initial begin : output_stall
    do @(posedge clk);
    while (!(taken_cnt >= 300 && pin_samples.size() > 20));
    hold_off <= 1'b1;
    repeat (STALL_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d of %0d samples taken, %0d results pending",
             taken_cnt, pushed_cnt, predicted_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== digital_input_debouncer.f =====
rtl/did_pkg.sv
rtl/did_if.sv
rtl/did_cfg.sv
rtl/did_core.sv
rtl/did_outreg.sv
rtl/digital_input_debouncer.sv
rtl/did_checker.sv
tb/sv/digital_input_debouncer_tb.sv
